[src/ldm_pkg.sv]
`timescale 1ns / 1ps

package ldm_pkg;

    localparam logic [11:0] YEAR_RESET = 12'd2024;
    localparam logic [5:0]  LENT_SPAN  = 6'd46;
    localparam int          CMP_STAGES = 5;

    localparam logic [2:0] MONTH_MARCH_E = 3'd3;
    localparam logic [2:0] MONTH_APRIL_E = 3'd4;
    localparam logic [1:0] MONTH_FEB_A   = 2'd2;
    localparam logic [1:0] MONTH_MARCH_A = 2'd3;

    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
    } ldm_in_t;

    typedef struct packed {
        logic       in_lent;
        logic [2:0] easter_month;
        logic [4:0] easter_day;
        logic [1:0] ash_month;
        logic [4:0] ash_day;
    } ldm_out_t;

    typedef struct packed {
        logic [2:0] easter_month;
        logic [4:0] easter_day;
        logic [1:0] ash_month;
        logic [4:0] ash_day;
    } ldm_dates_t;

endpackage

[src/lent_date_membership_unit.sv]
`timescale 1ns / 1ps

// channel  | handshake              | payload
// ---------+------------------------+---------------------------------------
// in       | in_valid / in_stall    | in_data  (day, month)
// out      | out_valid / out_stall  | out_data (in_lent, Easter, Ash Wed.)
// cfg      | cfg_we                 | cfg_data (year)
//
// A query's result is registered and held while stalled; a query taken in
// an output stall waits in a one-entry skid, which keeps in_stall registered.
// One query per cycle sustained without stalls, set by the single compare
// stage ahead of the result register. A year write (or reset, to 2024)
// runs the computus pipeline; in_stall stays high until new dates are held.
module lent_date_membership_unit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ldm_pkg::ldm_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ldm_pkg::ldm_out_t out_data,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_data
);
    import ldm_pkg::*;

    ldm_dates_t dates;
    logic       dates_ready;

    ldm_computus u_computus
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .dates       (dates),
        .dates_ready (dates_ready)
    );

    ldm_query u_query
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dates       (dates),
        .dates_ready (dates_ready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

[src/ldm_computus.sv]
`timescale 1ns / 1ps

module ldm_computus
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [11:0]         cfg_data,
    output ldm_pkg::ldm_dates_t dates,
    output logic                dates_ready
);
    import ldm_pkg::*;

    logic [11:0]           year_reg;
    logic                  start_reg;
    logic [CMP_STAGES-1:0] vld_reg;
    logic                  ready_reg;
    ldm_dates_t            dates_reg;
    ldm_dates_t            dates_next;

    // stage 1: golden number, century, year of century
    logic [24:0] b_prod;
    logic [26:0] a_prod;
    logic [7:0]  q19;
    logic [4:0]  a1_next, a1_reg;
    logic [5:0]  b1_next, b1_reg;
    logic [6:0]  c1_next, c1_reg;

    // stage 2: century corrections
    logic [5:0]  f_arg;
    logic [10:0] f_prod;
    logic        f_w;
    logic [5:0]  g_arg;
    logic [10:0] g_prod;
    logic [4:0]  a2_reg;
    logic [5:0]  b2_reg;
    logic [3:0]  d2_next, d2_reg;
    logic [3:0]  g2_next, g2_reg;
    logic [1:0]  e2_reg;
    logic [4:0]  i2_reg;
    logic [1:0]  k2_reg;
    logic        leap2_next, leap2_reg;

    // stage 3: epact mod 30
    logic [9:0]  hv;
    logic [19:0] h_prod;
    logic [4:0]  h3_next, h3_reg;
    logic [4:0]  a3_reg;
    logic [1:0]  e3_reg;
    logic [4:0]  i3_reg;
    logic [1:0]  k3_reg;
    logic        leap3_reg;

    // stage 4: weekday offset mod 7
    logic [6:0]  lv;
    logic [13:0] l_prod;
    logic [2:0]  l4_next, l4_reg;
    logic [4:0]  a4_reg;
    logic [4:0]  h4_reg;
    logic        leap4_reg;

    // stage 5: Easter month and day
    logic [8:0]  mv;
    logic [7:0]  sv;
    logic [2:0]  em5_next, em5_reg;
    logic [4:0]  ed5_next, ed5_reg;
    logic        leap5_reg;

    // stage 6: Ash Wednesday
    logic [5:0]  pos;
    logic [4:0]  feb_len;

    always_comb
    begin
        b_prod  = 25'(year_reg) * 25'd5243;
        b1_next = 6'(b_prod >> 19);
        c1_next = 7'(year_reg - 12'(b1_next) * 12'd100);
        a_prod  = 27'(year_reg) * 27'd27595;
        q19     = 8'(a_prod >> 19);
        a1_next = 5'(year_reg - 12'(q19) * 12'd19);
    end

    always_comb
    begin
        f_arg      = b1_reg + 6'd8;
        f_prod     = 11'(f_arg) * 11'd41;
        f_w        = f_prod[10];
        g_arg      = b1_reg - 6'(f_w) + 6'd1;
        g_prod     = 11'(g_arg) * 11'd43;
        g2_next    = 4'(g_prod >> 7);
        d2_next    = 4'(b1_reg >> 2);
        leap2_next = (c1_reg[1:0] == 2'd0) && ((c1_reg != 7'd0) || (b1_reg[1:0] == 2'd0));
    end

    always_comb
    begin
        hv      = 10'd19 * 10'(a2_reg) + 10'(b2_reg) + 10'd15 - 10'(d2_reg) - 10'(g2_reg);
        h_prod  = 20'(hv) * 20'd2185;
        h3_next = 5'(hv - 10'(h_prod >> 16) * 10'd30);
    end

    always_comb
    begin
        lv      = 7'd32 + {4'd0, e3_reg, 1'b0} + {1'b0, i3_reg, 1'b0}
                  - 7'(h3_reg) - 7'(k3_reg);
        l_prod  = 14'(lv) * 14'd147;
        l4_next = 3'(lv - 7'(l_prod >> 10) * 7'd7);
    end

    always_comb
    begin
        mv = 9'(a4_reg) + 9'd11 * 9'(h4_reg) + 9'd22 * 9'(l4_reg);
        sv = 8'(h4_reg) + 8'(l4_reg) + 8'd114 - ((mv >= 9'd451) ? 8'd7 : 8'd0);
        if (sv >= 8'd124)
        begin
            em5_next = MONTH_APRIL_E;
            ed5_next = 5'(sv - 8'd123);
        end
        else
        begin
            em5_next = MONTH_MARCH_E;
            ed5_next = 5'(sv - 8'd92);
        end
    end

    always_comb
    begin
        feb_len                 = leap5_reg ? 5'd29 : 5'd28;
        pos                     = (em5_reg == MONTH_MARCH_E) ? 6'(ed5_reg)
                                                             : 6'd31 + 6'(ed5_reg);
        dates_next.easter_month = em5_reg;
        dates_next.easter_day   = ed5_reg;
        if (pos > LENT_SPAN)
        begin
            dates_next.ash_month = MONTH_MARCH_A;
            dates_next.ash_day   = 5'(pos - LENT_SPAN);
        end
        else
        begin
            dates_next.ash_month = MONTH_FEB_A;
            dates_next.ash_day   = 5'(6'(feb_len) + pos - LENT_SPAN);
        end
    end

    // control: a year write restarts the pass and drops the ready flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg  <= YEAR_RESET;
            start_reg <= 1'b1;
            vld_reg   <= '0;
            ready_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            year_reg  <= cfg_data;
            start_reg <= 1'b1;
            vld_reg   <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            vld_reg   <= {vld_reg[CMP_STAGES-2:0], start_reg};
            if (vld_reg[CMP_STAGES-1])
            begin
                ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg    <= a1_next;
        b1_reg    <= b1_next;
        c1_reg    <= c1_next;

        a2_reg    <= a1_reg;
        b2_reg    <= b1_reg;
        d2_reg    <= d2_next;
        g2_reg    <= g2_next;
        e2_reg    <= b1_reg[1:0];
        i2_reg    <= 5'(c1_reg >> 2);
        k2_reg    <= c1_reg[1:0];
        leap2_reg <= leap2_next;

        h3_reg    <= h3_next;
        a3_reg    <= a2_reg;
        e3_reg    <= e2_reg;
        i3_reg    <= i2_reg;
        k3_reg    <= k2_reg;
        leap3_reg <= leap2_reg;

        l4_reg    <= l4_next;
        a4_reg    <= a3_reg;
        h4_reg    <= h3_reg;
        leap4_reg <= leap3_reg;

        em5_reg   <= em5_next;
        ed5_reg   <= ed5_next;
        leap5_reg <= leap4_reg;

        if (vld_reg[CMP_STAGES-1] && !cfg_we)
        begin
            dates_reg <= dates_next;
        end
    end

    assign dates       = dates_reg;
    assign dates_ready = ready_reg;

    a_ready_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ready_reg) |-> $past(vld_reg[CMP_STAGES-1]))
        else $error("dates marked ready without a finished pass");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> ((dates_reg.easter_month == MONTH_MARCH_E ||
                        dates_reg.easter_month == MONTH_APRIL_E) &&
                       (dates_reg.ash_month == MONTH_FEB_A ||
                        dates_reg.ash_month == MONTH_MARCH_A)))
        else $error("held month out of range");

    a_write_drops_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !ready_reg)
        else $error("ready flag survived a year write");

endmodule

[src/ldm_query.sv]
`timescale 1ns / 1ps

module ldm_query
(
    input  logic                clk,
    input  logic                rst_n,
    input  ldm_pkg::ldm_dates_t dates,
    input  logic                dates_ready,
    input  logic                in_valid,
    output logic                in_stall,
    input  ldm_pkg::ldm_in_t    in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ldm_pkg::ldm_out_t   out_data
);
    import ldm_pkg::*;

    logic     skid_v_reg;
    ldm_in_t  skid_reg;
    logic     out_v_reg;
    ldm_out_t out_reg;
    ldm_in_t  src;
    ldm_out_t res;
    logic     move;
    logic     acc;
    logic [8:0] q_key;
    logic [8:0] ash_key;
    logic [8:0] eas_key;

    assign move     = !out_v_reg || !out_stall;
    assign in_stall = skid_v_reg || !dates_ready;
    assign acc      = in_valid && !in_stall;
    assign src      = skid_v_reg ? skid_reg : in_data;

    // dates compare as (month, day) pairs, no validation of the query
    always_comb
    begin
        q_key            = {src.month, src.day};
        ash_key          = {2'b00, dates.ash_month, dates.ash_day};
        eas_key          = {1'b0, dates.easter_month, dates.easter_day};
        res.in_lent      = (q_key >= ash_key) && (q_key < eas_key);
        res.easter_month = dates.easter_month;
        res.easter_day   = dates.easter_day;
        res.ash_month    = dates.ash_month;
        res.ash_day      = dates.ash_day;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else if (move)
        begin
            skid_v_reg <= 1'b0;
            out_v_reg  <= skid_v_reg || acc;
        end
        else if (acc)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg <= res;
        end
        else if (acc)
        begin
            skid_reg <= in_data;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held with an empty result register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_v_reg && !out_stall) |=> (!skid_v_reg && out_v_reg))
        else $error("skid entry not moved on a free output");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && out_stall) |=> (out_v_reg && $stable(out_reg)))
        else $error("stalled result changed");

endmodule
